// ----- hdl/uer_pkg.sv -----
// Shared types and constants of the ultrasonic echo ranger.
package uer_pkg;

  // Sensors the trigger and echo buses carry.
  localparam int MAX_SENSORS = 8;

  // Distance = pulse_us * DIST_NUM / (2**DIV_SHIFT * DIV_ODD) mm.
  localparam int DIST_NUM  = 343;
  localparam int DIV_SHIFT = 4;
  localparam int DIV_ODD   = 125;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TRIGGER_WIDTH = 3'd0;
  localparam logic [2:0] REG_TIMEOUT       = 3'd1;
  localparam logic [2:0] REG_MIN_RANGE     = 3'd2;
  localparam logic [2:0] REG_MAX_RANGE     = 3'd3;
  localparam logic [2:0] REG_SENSOR_COUNT  = 3'd4;

  typedef struct packed {
    logic [7:0]  trigger_width;
    logic [14:0] timeout;
    logic [15:0] near_limit;
    logic [15:0] far_limit;
    logic [3:0]  sensor_count;
  } uer_cfg_t;

  // One classified tick on its way from the front to the back.
  typedef struct packed {
    logic [7:0] trigger_lines;
    logic       done;
    logic       timed_out;
    logic [2:0] sensor;
  } uer_evt_t;

endpackage

// ----- hdl/uer_front.sv -----
// Front end: tick sequencer that tracks trigger, echo wait and pulse timing.
module uer_front
  import uer_pkg::*;
#(
  parameter int COUNT_BITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  uer_cfg_t              cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  measure_request_i,
  input  logic [7:0]            echo_levels_i,
  output logic                  evt_valid_o,
  input  logic                  evt_ready_i,
  output uer_evt_t              evt_o,
  output logic [COUNT_BITS-1:0] pulse_o
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_TRIGGER = 2'd1;
  localparam logic [1:0] PH_WAIT    = 2'd2;
  localparam logic [1:0] PH_PULSE   = 2'd3;

  localparam int CW = (COUNT_BITS + 1 > 15) ? COUNT_BITS + 1 : 15;

  logic [1:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] tick_q, tick_d;
  logic [COUNT_BITS-1:0] start_q, start_d;
  logic [2:0]            cur_q, cur_d;

  logic                  accept;
  logic [3:0]            active_n;

  assign in_ready_o  = evt_ready_i;
  assign evt_valid_o = in_valid_i;
  assign accept      = in_valid_i && evt_ready_i;

  always_comb begin
    if (cfg_i.sensor_count == 4'd0) begin
      active_n = 4'd1;
    end else if (cfg_i.sensor_count > 4'(MAX_SENSORS)) begin
      active_n = 4'(MAX_SENSORS);
    end else begin
      active_n = cfg_i.sensor_count;
    end
  end

  always_comb begin
    logic [1:0]            ph;
    logic [2:0]            cs;
    logic [COUNT_BITS-1:0] tick;
    logic [COUNT_BITS-1:0] t_trig;
    logic [COUNT_BITS:0]   t_next;
    logic                  echo;
    logic                  win_end;
    logic                  fin;
    logic                  fin_to;

    ph      = phase_q;
    cs      = cur_q;
    tick    = tick_q;
    phase_d = phase_q;
    tick_d  = tick_q;
    start_d = start_q;
    cur_d   = cur_q;
    evt_o   = '0;
    pulse_o = '0;
    fin     = 1'b0;
    fin_to  = 1'b0;

    // Start on request; a stale sensor index past the count restarts at 0.
    if (ph == PH_IDLE && measure_request_i) begin
      cs      = ({1'b0, cur_q} >= active_n) ? 3'd0 : cur_q;
      ph      = PH_TRIGGER;
      tick    = '0;
      cur_d   = cs;
      phase_d = PH_TRIGGER;
      tick_d  = '0;
    end

    echo    = echo_levels_i[cs];
    t_trig  = tick + 1'b1;
    t_next  = {1'b0, tick} + 1'b1;
    win_end = (CW'(t_next) >= CW'(cfg_i.timeout)) || t_next[COUNT_BITS];

    case (ph)
      PH_TRIGGER: begin
        evt_o.trigger_lines = 8'd1 << cs;
        if (t_trig >= COUNT_BITS'(cfg_i.trigger_width) || t_trig == '0) begin
          phase_d = PH_WAIT;
          tick_d  = '0;
        end else begin
          tick_d = t_trig;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          start_d = tick;
          phase_d = PH_PULSE;
        end
        if (win_end) begin
          fin    = 1'b1;
          fin_to = 1'b1;
        end else begin
          tick_d = t_next[COUNT_BITS-1:0];
        end
      end
      PH_PULSE: begin
        if (!echo) begin
          fin     = 1'b1;
          pulse_o = tick - start_q;
        end else if (win_end) begin
          fin    = 1'b1;
          fin_to = 1'b1;
        end else begin
          tick_d = t_next[COUNT_BITS-1:0];
        end
      end
      default: begin
      end
    endcase

    // Report and advance the rotation.
    if (fin) begin
      evt_o.done      = 1'b1;
      evt_o.sensor    = cs;
      evt_o.timed_out = fin_to;
      cur_d   = ({1'b0, cs} + 4'd1 >= active_n) ? 3'd0 : 3'(cs + 3'd1);
      phase_d = PH_IDLE;
      tick_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      start_q <= '0;
      cur_q   <= 3'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      start_q <= start_d;
      cur_q   <= cur_d;
    end
  end

endmodule

// ----- hdl/uer_fifo.sv -----
// Short queue that decouples the tick sequencer from the distance pipeline.
module uer_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != (AW+1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/uer_back.sv -----
// Back end: distance scaling, range clamp and the output register.
module uer_back
  import uer_pkg::*;
#(
  parameter int COUNT_BITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  uer_cfg_t              cfg_i,
  input  logic                  evt_valid_i,
  output logic                  evt_ready_o,
  input  uer_evt_t              evt_i,
  input  logic [COUNT_BITS-1:0] pulse_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           out_data_o
);

  localparam int XW = COUNT_BITS + 9;          // pulse * 343
  localparam int NW = XW - DIV_SHIFT;          // after the /16
  localparam int SH = NW + $clog2(DIV_ODD);    // reciprocal scale
  localparam int PW = 2 * NW + 1;              // reciprocal product
  localparam int QW = PW - SH;                 // quotient bits
  localparam int DW = (QW > 16) ? QW : 16;
  localparam logic [63:0] RECIP_W = ((64'd1 << SH) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD);
  localparam logic [NW:0] RECIP   = RECIP_W[NW:0];

  logic          en;
  logic          v1_q, v2_q, out_valid_q;
  uer_evt_t      c1_q, c2_q;
  logic [XW-1:0] x1_q;
  logic [PW-1:0] p2_q;
  logic [31:0]   out_data_q;

  logic [DW-1:0] q_ext, min_ext, max_ext, d_ext;
  logic [15:0]   dist_mm;

  // Advance the whole pipe whenever the output slot frees up.
  assign en          = !out_valid_q || out_ready_i;
  assign evt_ready_o = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    q_ext   = DW'(p2_q[PW-1:SH]);
    min_ext = DW'(cfg_i.near_limit);
    max_ext = DW'(cfg_i.far_limit);
    if (q_ext < min_ext) begin
      d_ext = min_ext;
    end else if (q_ext > max_ext) begin
      d_ext = max_ext;
    end else begin
      d_ext = q_ext;
    end
    dist_mm = (c2_q.done && !c2_q.timed_out) ? d_ext[15:0] : 16'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q       <= evt_i;
      x1_q       <= XW'(pulse_i) * XW'(DIST_NUM);
      c2_q       <= c1_q;
      p2_q       <= PW'(x1_q[XW-1:DIV_SHIFT]) * PW'(RECIP);
      out_data_q <= {3'd0, c2_q.timed_out, dist_mm, c2_q.sensor, c2_q.done,
                     c2_q.trigger_lines};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= evt_valid_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

endmodule

// ----- hdl/ultrasonic_echo_ranger.sv -----
// Top level of the ultrasonic echo ranger: register port, sequencer, queue, back end.
//
// Each slave item is one microsecond tick: tdata bit 0 is measure_request,
// bits 8:1 the echo level of each sensor. Every tick yields exactly one
// master item carrying the trigger levels to drive and, on the tick that a
// measurement ends, done_res with the sensor, distance in mm and timeout
// flag. Distance is floor(pulse_us * 343 / 2000), clamped to the min/max
// registers; a timeout reports distance 0.
// Throughput is one tick per cycle while the receiver does not stall: the
// sequencer takes each tick as it arrives and the scaling runs as a
// three-register pipeline behind a four-entry queue. From acceptance, a
// result passes the queue, two pipe stages and the output register.
// When the receiver stalls, the output register holds and the pipeline
// freezes; the queue keeps taking ticks until it fills, then s_axis_tready
// drops. Reset clears the sequencer to idle on sensor 0, empties the queue
// and pipe and loads the register defaults (trigger 10, timeout 25000,
// range 20..4000 mm, two sensors). Write registers only while idle.
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int COUNT_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] measure_request, [8:1] echo_levels, [15:9] zero
  input  logic [15:0] s_axis_tdata,
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] trigger_lines, [8] done_res, [11:9] sensor_index,
  // [27:12] distance_mm, [28] timed_out, [31:29] zero
  output logic [31:0] m_axis_tdata
);

  localparam int EW = $bits(uer_evt_t) + COUNT_BITS;

  uer_cfg_t cfg_q;
  logic [2:0] reg_idx;

  logic                  f_valid, f_ready;
  uer_evt_t              f_evt;
  logic [COUNT_BITS-1:0] f_pulse;
  logic                  b_valid, b_ready;
  logic [EW-1:0]         b_data;
  uer_evt_t              b_evt;
  logic [COUNT_BITS-1:0] b_pulse;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Register write on the access phase; out-of-map indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_width <= 8'd10;
      cfg_q.timeout       <= 15'd25000;
      cfg_q.near_limit    <= 16'd20;
      cfg_q.far_limit     <= 16'd4000;
      cfg_q.sensor_count  <= 4'd2;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_TRIGGER_WIDTH: cfg_q.trigger_width <= pwdata[7:0];
        REG_TIMEOUT:       cfg_q.timeout       <= pwdata[14:0];
        REG_MIN_RANGE:     cfg_q.near_limit    <= pwdata[15:0];
        REG_MAX_RANGE:     cfg_q.far_limit     <= pwdata[15:0];
        REG_SENSOR_COUNT:  cfg_q.sensor_count  <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TRIGGER_WIDTH: prdata = {24'd0, cfg_q.trigger_width};
      REG_TIMEOUT:       prdata = {17'd0, cfg_q.timeout};
      REG_MIN_RANGE:     prdata = {16'd0, cfg_q.near_limit};
      REG_MAX_RANGE:     prdata = {16'd0, cfg_q.far_limit};
      REG_SENSOR_COUNT:  prdata = {28'd0, cfg_q.sensor_count};
      default:           prdata = 32'd0;
    endcase
  end

  uer_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .measure_request_i (s_axis_tdata[0]),
    .echo_levels_i     (s_axis_tdata[8:1]),
    .evt_valid_o       (f_valid),
    .evt_ready_i       (f_ready),
    .evt_o             (f_evt),
    .pulse_o           (f_pulse)
  );

  uer_fifo #(
    .WIDTH(EW),
    .DEPTH(4)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_evt, f_pulse}),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  assign b_evt   = b_data[EW-1:COUNT_BITS];
  assign b_pulse = b_data[COUNT_BITS-1:0];

  uer_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .evt_valid_i (b_valid),
    .evt_ready_o (b_ready),
    .evt_i       (b_evt),
    .pulse_i     (b_pulse),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- verif/ultrasonic_echo_ranger_test.sv -----
// Self-checking testbench of the ultrasonic echo ranger: tick stream, registers, results.
module ultrasonic_echo_ranger_test;
  timeunit 1ns;
  timeprecision 1ps;
  import uer_pkg::*;

  // Window counter range of the block (COUNT_BITS left at 15).
  localparam int unsigned COUNT_MAX        = 32767;
  // Distance scaling: mm = pulse_us * 343 / 2000.
  localparam int unsigned SOUND_NUM        = 343;
  localparam int unsigned SOUND_DEN        = 2000;
  // Cycles without any accepted item before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  // Long receiver hold-off: starts once this many ticks went in.
  localparam int unsigned LONG_HOLD_AT     = 100;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  // Idle margin before the registers are reprogrammed and at the end of the run.
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned TAIL_CYCLES      = 20;

  typedef enum logic [1:0] {
    RANGE_IDLE,
    RANGE_TRIGGER,
    RANGE_WAIT,
    RANGE_PULSE
  } range_phase_e;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  // One input tick as it is planned.
  typedef struct packed {
    logic       measure_request;
    logic [7:0] echo_levels;
  } tick_t;

  // One result item, laid out exactly like m_axis_tdata[28:0].
  typedef struct packed {
    logic        timed_out;
    logic [15:0] distance_mm;
    logic [2:0]  sensor_index;
    logic        done_res;
    logic [7:0]  trigger_lines;
  } echo_result_t;

  // Block inputs start at known values; everything after that is driven at the clock edge.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [0] measure_request, [8:1] echo_levels, [15:9] zero
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] trigger_lines, [8] done_res, [11:9] sensor_index,
  // [27:12] distance_mm, [28] timed_out, [31:29] zero
  logic [31:0] m_axis_tdata;

  ultrasonic_echo_ranger i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Ranging predictor: its own copy of the registers and the sequencer state.
  // ---------------------------------------------------------------------------
  uer_cfg_t     cfg_shadow;
  range_phase_e range_phase    = RANGE_IDLE;
  logic [14:0]  window_tick    = '0;
  logic [14:0]  echo_rise_tick = '0;
  logic [2:0]   active_sensor  = '0;

  // Sensors in the rotation, with out-of-range counts pulled back to 1..MAX_SENSORS.
  function automatic int unsigned sensors_in_rotation();
    int unsigned n;
    n = cfg_shadow.sensor_count;
    if (n < 1) n = 1;
    if (n > MAX_SENSORS) n = MAX_SENSORS;
    return n;
  endfunction

  function automatic logic [2:0] next_sensor(input logic [2:0] s);
    return (s + 1 >= sensors_in_rotation()) ? 3'd0 : s + 3'd1;
  endfunction

  // Zero width or zero timeout behave as one tick.
  function automatic int unsigned trigger_ticks();
    return (cfg_shadow.trigger_width == '0) ? 1 : cfg_shadow.trigger_width;
  endfunction

  function automatic int unsigned window_ticks();
    return (cfg_shadow.timeout == '0) ? 1 : cfg_shadow.timeout;
  endfunction

  // Step the shared wait/pulse window; 1 when the window is used up.
  function automatic bit window_spent();
    int unsigned t;
    t = window_tick + 1;
    if (t >= cfg_shadow.timeout || t > COUNT_MAX) return 1'b1;
    window_tick = 15'(t);
    return 1'b0;
  endfunction

  // End the measurement: scale and clamp the pulse, advance the rotation.
  function automatic echo_result_t close_measurement(input bit lost, input logic [14:0] pulse_us);
    echo_result_t r;
    logic [31:0]  mm;
    r  = '0;
    mm = '0;
    if (!lost) begin
      mm = (32'(pulse_us) * SOUND_NUM) / SOUND_DEN;
      // With min above max the lower clamp wins for short distances.
      if (mm < cfg_shadow.near_limit) mm = 32'(cfg_shadow.near_limit);
      else if (mm > cfg_shadow.far_limit) mm = 32'(cfg_shadow.far_limit);
    end
    r.done_res     = 1'b1;
    r.sensor_index = active_sensor;
    r.distance_mm  = mm[15:0];
    r.timed_out    = lost;
    active_sensor  = next_sensor(active_sensor);
    range_phase    = RANGE_IDLE;
    window_tick    = '0;
    return r;
  endfunction

  // Expected result of one accepted tick.
  function automatic echo_result_t ranger_tick(input logic req, input logic [7:0] echo);
    echo_result_t r;
    logic         level;
    r = '0;
    if (range_phase == RANGE_IDLE) begin
      if (!req) return r;
      // A sensor left beyond a shrunk rotation restarts at sensor 0.
      if (active_sensor >= sensors_in_rotation()) active_sensor = '0;
      range_phase = RANGE_TRIGGER;
      window_tick = '0;
    end
    level = echo[active_sensor];
    case (range_phase)
      RANGE_TRIGGER: begin
        // Echo is ignored while the trigger is high.
        r.trigger_lines = 8'd1 << active_sensor;
        window_tick     = window_tick + 15'd1;
        if (window_tick >= cfg_shadow.trigger_width || window_tick == '0) begin
          range_phase = RANGE_WAIT;
          window_tick = '0;
        end
      end
      RANGE_WAIT: begin
        // A high level on the very first window tick counts as the rise.
        if (level) begin
          echo_rise_tick = window_tick;
          range_phase    = RANGE_PULSE;
        end
        if (window_spent()) r = close_measurement(1'b1, '0);
      end
      default: begin
        if (!level) r = close_measurement(1'b0, window_tick - echo_rise_tick);
        else if (window_spent()) r = close_measurement(1'b1, '0);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tick driver: bursts of random length with random gaps between them.
  // ---------------------------------------------------------------------------
  tick_t        tick_queue[$];
  echo_result_t expected_results[$];
  int unsigned  ticks_planned  = 0;
  int unsigned  ticks_accepted = 0;
  int unsigned  burst_left     = 0;
  int unsigned  gap_left       = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.insert(expected_results.size(),
                                ranger_tick(s_axis_tdata[0], s_axis_tdata[8:1]));
        void'(tick_queue.pop_front());
        ticks_accepted++;
      end
      // Hold the offered item until it is taken.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, tick_queue[0].echo_levels, tick_queue[0].measure_request};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              4, 5, 6, 7: gap_left = $urandom_range(1, 3);
              default:    gap_left = $urandom_range(8, 25);
            endcase
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: changing stall patterns plus one long hold-off.
  // ---------------------------------------------------------------------------
  rx_mode_e    stall_mode     = RX_OPEN;
  int unsigned mode_left      = 0;
  int unsigned hold_left      = 0;
  int unsigned rx_cycle       = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Drop tready for a long stretch while the sender keeps offering,
      // so the internal queue fills and the input stalls.
      if (!long_hold_done && ticks_accepted >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          RX_OPEN:  m_axis_tready <= 1'b1;
          RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: m_axis_tready <= 1'($urandom_range(0, 1));
          default:  m_axis_tready <= (rx_cycle % 7) > 1;
        endcase
      end
      rx_cycle++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare every taken result with the oldest expectation.
  // ---------------------------------------------------------------------------
  echo_result_t observed;
  echo_result_t wanted;
  int unsigned  errors             = 0;
  int unsigned  measurements_seen  = 0;
  int unsigned  timeouts_seen      = 0;
  logic [7:0]   sensors_seen       = '0;

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      observed = echo_result_t'(m_axis_tdata[28:0]);
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result %0h expected none, got one", $time, m_axis_tdata);
      end else begin
        wanted = expected_results.pop_front();
        check_field("trigger_lines", 16'(wanted.trigger_lines), 16'(observed.trigger_lines));
        check_field("done_res", 16'(wanted.done_res), 16'(observed.done_res));
        check_field("sensor_index", 16'(wanted.sensor_index), 16'(observed.sensor_index));
        check_field("distance_mm", wanted.distance_mm, observed.distance_mm);
        check_field("timed_out", 16'(wanted.timed_out), 16'(observed.timed_out));
        if (wanted.done_res) begin
          measurements_seen++;
          sensors_seen[wanted.sensor_index] = 1'b1;
          if (wanted.timed_out) timeouts_seen++;
        end
      end
    end
  end

  // Watchdog: abandon the run when no item moves for too long.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus planning.
  // ---------------------------------------------------------------------------
  logic [2:0]  plan_sensor     = '0;
  int unsigned settings_loaded = 0;

  task automatic push_tick(input logic req, input logic [7:0] echo);
    tick_t planned;
    planned.measure_request = req;
    planned.echo_levels     = echo;
    tick_queue.insert(tick_queue.size(), planned);
    ticks_planned++;
  endtask

  // Tick carrying the given level on the planned sensor, other echoes random.
  task automatic push_echo(input logic level);
    logic [7:0] e;
    e              = 8'($urandom);
    e[plan_sensor] = level;
    push_tick(1'b0, e);
  endtask

  // Pause the sender until every expected result has come back.
  task automatic await_results();
    while (tick_queue.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    // The register takes the value on the access edge with pready high.
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TRIGGER_WIDTH: cfg_shadow.trigger_width = value[7:0];
      REG_TIMEOUT:       cfg_shadow.timeout       = value[14:0];
      REG_MIN_RANGE:     cfg_shadow.near_limit    = value[15:0];
      REG_MAX_RANGE:     cfg_shadow.far_limit     = value[15:0];
      REG_SENSOR_COUNT:  cfg_shadow.sensor_count  = value[3:0];
      default: ;
    endcase
  endtask

  // Reprogram every register once the block has gone quiet.
  task automatic load_settings(input int unsigned tw, input int unsigned to,
                               input int unsigned mn, input int unsigned mx,
                               input int unsigned cnt);
    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_write(REG_TRIGGER_WIDTH, tw);
    apb_write(REG_TIMEOUT, to);
    apb_write(REG_MIN_RANGE, mn);
    apb_write(REG_MAX_RANGE, mx);
    apb_write(REG_SENSOR_COUNT, cnt);
    settings_loaded++;
    plan_sensor = active_sensor;
  endtask

  // One well-formed measurement on the planned sensor: request, trigger ticks
  // (busy requests sprinkled in), a low gap, a high pulse and the falling tick.
  // With no pulse the gap must cover the whole window so that it times out.
  task automatic queue_measurement(input int unsigned gap, input int unsigned pulse_len);
    int unsigned i;
    if (plan_sensor >= sensors_in_rotation()) plan_sensor = '0;
    push_tick(1'b1, 8'($urandom));
    for (i = 1; i < trigger_ticks(); i++) push_tick(1'($urandom), 8'($urandom));
    for (i = 0; i < gap; i++) push_echo(1'b0);
    for (i = 0; i < pulse_len; i++) push_echo(1'b1);
    if (pulse_len > 0) push_echo(1'b0);
    plan_sensor = next_sensor(plan_sensor);
  endtask

  initial begin : stimulus
    int unsigned i;
    int unsigned p;
    int unsigned mark;
    int unsigned pick;
    int unsigned gap;
    int unsigned pulse;
    // Random phases: trigger width, timeout, min, max, sensor count, ticks.
    int unsigned set_tw  [5] = '{1, 0, 3, 255, 2};
    int unsigned set_to  [5] = '{40, 0, 60, 32767, 2000};
    int unsigned set_min [5] = '{0, 0, 3, 65535, 2};
    int unsigned set_max [5] = '{65535, 65535, 1, 0, 30};
    int unsigned set_cnt [5] = '{8, 0, 15, 2, 5};
    int unsigned set_len [5] = '{70, 40, 70, 250, 70};

    // Register values after reset.
    cfg_shadow.trigger_width = 8'd10;
    cfg_shadow.timeout       = 15'd25000;
    cfg_shadow.near_limit    = 16'd20;
    cfg_shadow.far_limit     = 16'd4000;
    cfg_shadow.sensor_count  = 4'd2;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: short trigger and window, three sensors, no clamping.
    load_settings(2, 8, 0, 65535, 3);
    // Sensor 0: request while busy, echo already high on the first window tick.
    push_tick(1'b1, 8'hFF);
    push_tick(1'b1, 8'h00);
    push_tick(1'b0, 8'h01);
    push_tick(1'b0, 8'hFF);
    push_tick(1'b0, 8'hFE);
    // Sensor 1: echo never rises, the wait runs out.
    push_tick(1'b1, 8'h00);
    push_tick(1'b0, 8'hFD);
    for (i = 0; i < 8; i++) push_tick(1'b0, (i % 2) ? 8'hFD : 8'h00);
    // Sensor 2: echo rises and stays high past the window.
    push_tick(1'b1, 8'h00);
    push_tick(1'b0, 8'h00);
    repeat (8) push_tick(1'b0, 8'h04);
    push_tick(1'b0, 8'h00);

    // Random part, one register setting per phase.
    for (p = 0; p < 5; p++) begin
      load_settings(set_tw[p], set_to[p], set_min[p], set_max[p], set_cnt[p]);
      mark = ticks_planned;
      while (ticks_planned - mark < set_len[p]) begin
        pick = $urandom_range(0, 9);
        if (pick >= 8) begin
          // Noise: stray requests on random echoes, then run any started
          // measurement to its end and resync with the block.
          repeat ($urandom_range(5, 30)) push_tick($urandom_range(0, 5) == 0, 8'($urandom));
          repeat (trigger_ticks()) push_tick(1'b0, 8'h00);
          push_tick(1'b0, 8'hFF);
          push_tick(1'b0, 8'h00);
          await_results();
          plan_sensor = active_sensor;
        end else if (pick == 7 && window_ticks() <= 64) begin
          queue_measurement(window_ticks(), 0);
        end else begin
          gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          pulse = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(1, 30);
          queue_measurement(gap, pulse);
        end
        repeat ($urandom_range(0, 3)) push_tick(1'b0, 8'($urandom));
      end
    end

    await_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Checked %0d ticks under %0d register settings: %0d measurements, %0d timed out,",
             ticks_accepted, settings_loaded, measurements_seen, timeouts_seen);
    $display("sensors reporting %b, %0d mismatches", sensors_seen, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/uer_pkg.sv
hdl/uer_front.sv
hdl/uer_fifo.sv
hdl/uer_back.sv
hdl/ultrasonic_echo_ranger.sv
verif/ultrasonic_echo_ranger_test.sv
